// File: src/mpv_pkg.sv
// Package for the Merkle branch verifier: hash and word types,
// SHA-256 constants and the round/schedule helper functions.
// No dependencies.
package mpv_pkg;

   typedef logic [31:0]  word_type;
   typedef logic [255:0] hash_type;
   typedef logic [511:0] block_type;

   localparam int BlockWords = 16;
   localparam int HashWords  = 8;
   localparam int LastRound  = 63;

   // request opcodes
   localparam logic OpStart   = 1'b0;
   localparam logic OpSibling = 1'b1;

   localparam hash_type IvHash =
      256'h6a09e667_bb67ae85_3c6ef372_a54ff53a_510e527f_9b05688c_1f83d9ab_5be0cd19;

   // second block of a 64-byte message: marker bit, zeros, length 512
   localparam block_type PadBlock64 = {8'h80, 440'b0, 64'd512};

   // tail of a 32-byte message block: marker bit, zeros, length 256
   localparam hash_type PadTail32 = {8'h80, 184'b0, 64'd256};

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      unique case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

// File: src/merkle_proof_verifier_core.sv
// Merkle branch verifier with double SHA-256 on one shared round unit.
// Depends on mpv_pkg (types, round constants, sigma functions).
//
// A start request (opcode 0) loads the leaf hash, index and count.
// A sibling request runs three SHA-256 compressions back to back on a single
// round unit, one round per cycle: 64 rounds plus a load and an add step per
// compression, and a final step to update the running hash; req_stall stays
// high throughout. The final request adds a compare step, then the result
// is held on rsp_* until taken, with req_stall high meanwhile. The expected
// root lies in four 64-bit registers at byte addresses 0, 8, 16 and 24;
// write them only while the block is idle.
module merkle_proof_verifier_core #(
   parameter int INDEX_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [63:0] req_hash_word0,
   input  logic [63:0] req_hash_word1,
   input  logic [63:0] req_hash_word2,
   input  logic [63:0] req_hash_word3,
   input  logic [31:0] req_leaf_index,
   input  logic [31:0] req_leaf_count,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_proof_valid,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [2:0] {
      IDLE, LOAD, ROUND, ADD, UPDATE, CHECK, RESULT
   } state_type;

   localparam logic [1:0] BlkPair  = 2'd0;
   localparam logic [1:0] BlkPad   = 2'd1;
   localparam logic [1:0] BlkOuter = 2'd2;

   state_type             state_ff, state_in;
   logic [63:0]           root_ff [4];
   mpv_pkg::hash_type     running_ff, running_in;
   mpv_pkg::hash_type     sib_ff, sib_in;
   mpv_pkg::hash_type     h_ff, h_in;
   mpv_pkg::word_type     v_ff [8];
   mpv_pkg::word_type     v_in [8];
   mpv_pkg::word_type     w_ff [16];
   mpv_pkg::word_type     w_in [16];
   logic [INDEX_BITS-1:0] position_ff, position_in;
   logic [5:0]            round_ff, round_in;
   logic [1:0]            blk_ff, blk_in;
   logic                  count_zero_ff, count_zero_in;
   logic                  active_ff, active_in;
   logic                  last_ff, last_in;
   logic                  result_ff, result_in;

   mpv_pkg::block_type    block;
   mpv_pkg::hash_type     root_hash;
   mpv_pkg::word_type     t1, t2;

   assign csr_pready = 1'b1;
   assign csr_prdata = root_ff[csr_paddr[4:3]];
   assign root_hash  = {root_ff[0], root_ff[1], root_ff[2], root_ff[3]};

   assign req_stall       = (state_ff != IDLE);
   assign rsp_valid       = (state_ff == RESULT);
   assign rsp_proof_valid = result_ff;

   always_comb begin
      state_in      = state_ff;
      running_in    = running_ff;
      sib_in        = sib_ff;
      h_in          = h_ff;
      v_in          = v_ff;
      w_in          = w_ff;
      position_in   = position_ff;
      round_in      = round_ff;
      blk_in        = blk_ff;
      count_zero_in = count_zero_ff;
      active_in     = active_ff;
      last_in       = last_ff;
      result_in     = result_ff;
      block         = mpv_pkg::PadBlock64;
      t1 = v_ff[7] + mpv_pkg::big_sigma1(v_ff[4]) +
           ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) +
           mpv_pkg::round_k(round_ff) + w_ff[0];
      t2 = mpv_pkg::big_sigma0(v_ff[0]) +
           ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               if (req_opcode == mpv_pkg::OpStart) begin
                  running_in = {req_hash_word0, req_hash_word1,
                                req_hash_word2, req_hash_word3};
                  position_in   = INDEX_BITS'(req_leaf_index);
                  count_zero_in = (req_leaf_count == 32'd0);
                  active_in     = 1'b1;
                  if (req_last_item) state_in = CHECK;
               end else if (active_ff) begin
                  sib_in   = {req_hash_word0, req_hash_word1,
                              req_hash_word2, req_hash_word3};
                  last_in  = req_last_item;
                  blk_in   = BlkPair;
                  state_in = LOAD;
               end
               // drop siblings that arrive with no proof open
            end
         end
         LOAD: begin
            round_in = 6'd0;
            unique case (blk_ff)
               BlkPair: begin
                  block = position_ff[0] ? {sib_ff, running_ff} : {running_ff, sib_ff};
                  h_in  = mpv_pkg::IvHash;
                  for (int i = 0; i < mpv_pkg::HashWords; i++)
                     v_in[i] = mpv_pkg::IvHash[255-32*i -: 32];
               end
               BlkPad: begin
                  block = mpv_pkg::PadBlock64;
                  for (int i = 0; i < mpv_pkg::HashWords; i++)
                     v_in[i] = h_ff[255-32*i -: 32];
               end
               default: begin
                  // outer hash over the 32-byte inner digest
                  block = {h_ff, mpv_pkg::PadTail32};
                  h_in  = mpv_pkg::IvHash;
                  for (int i = 0; i < mpv_pkg::HashWords; i++)
                     v_in[i] = mpv_pkg::IvHash[255-32*i -: 32];
               end
            endcase
            for (int i = 0; i < mpv_pkg::BlockWords; i++)
               w_in[i] = block[511-32*i -: 32];
            state_in = ROUND;
         end
         ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int i = 0; i < mpv_pkg::BlockWords - 1; i++)
               w_in[i] = w_ff[i+1];
            w_in[15] = w_ff[0] + mpv_pkg::small_sigma0(w_ff[1]) + w_ff[9] +
                       mpv_pkg::small_sigma1(w_ff[14]);
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(mpv_pkg::LastRound)) state_in = ADD;
         end
         ADD: begin
            for (int i = 0; i < mpv_pkg::HashWords; i++)
               h_in[255-32*i -: 32] = h_ff[255-32*i -: 32] + v_ff[i];
            if (blk_ff == BlkOuter) begin
               state_in = UPDATE;
            end else begin
               blk_in   = blk_ff + 2'd1;
               state_in = LOAD;
            end
         end
         UPDATE: begin
            running_in  = h_ff;
            position_in = position_ff >> 1;
            state_in    = last_ff ? CHECK : IDLE;
         end
         CHECK: begin
            result_in = (running_ff == root_hash) && !count_zero_ff;
            state_in  = RESULT;
         end
         RESULT: begin
            if (!rsp_stall) begin
               active_in = 1'b0;
               state_in  = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         running_ff    <= '0;
         position_ff   <= '0;
         count_zero_ff <= 1'b0;
         active_ff     <= 1'b0;
         for (int i = 0; i < 4; i++) root_ff[i] <= '0;
      end else begin
         state_ff      <= state_in;
         running_ff    <= running_in;
         position_ff   <= position_in;
         count_zero_ff <= count_zero_in;
         active_ff     <= active_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            root_ff[csr_paddr[4:3]] <= csr_pwdata;
      end
      sib_ff    <= sib_in;
      h_ff      <= h_in;
      v_ff      <= v_in;
      w_ff      <= w_in;
      round_ff  <= round_in;
      blk_ff    <= blk_in;
      last_ff   <= last_in;
      result_ff <= result_in;
   end

`ifndef NO_ASSERTIONS
   a_busy_while_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is pending");

   a_blk_advance : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ADD && blk_ff != BlkOuter) |=>
         (state_ff == LOAD && blk_ff == $past(blk_ff) + 2'd1))
      else $error("compression sequence skipped a block");

   a_round_start : assert property (@(posedge clock) disable iff (reset)
      (state_ff == LOAD) |=> (state_ff == ROUND && round_ff == 6'd0))
      else $error("round counter not cleared at block load");

   a_close_proof : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> (!active_ff && state_ff == IDLE))
      else $error("proof still open after its result");
`endif

endmodule
